### src/rnsalu_pkg.sv
// ----------------------------------------------------------------------------
// rnsalu_pkg - shared definitions for the residue modular ALU
// Operation codes, field widths, the channel prime table and the word type
// that carries one operation into the arithmetic pipeline.
// ----------------------------------------------------------------------------
package rnsalu_pkg;

    localparam int RADIX_BITS   = 60;
    localparam int HALF_BITS    = 30;
    localparam int C_W          = 31;
    localparam int CH_W         = 2;
    localparam int NUM_CHANNELS = 4;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_SUB = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [CH_W-1:0]       channel;
        logic [RADIX_BITS-1:0] a;
        logic [RADIX_BITS-1:0] b;
    } op_t;

    // Prime of each residue channel, all of the form 2^60 - c.
    function automatic logic [RADIX_BITS-1:0] prime_of(input logic [CH_W-1:0] ch);
        logic [RADIX_BITS-1:0] p;
        case (ch)
            2'd0:    p = 60'd1152921504002872321;
            2'd1:    p = 60'd1152921503566671361;
            2'd2:    p = 60'd1152921503264686081;
            default: p = 60'd1152921503096916481;
        endcase
        return p;
    endfunction

    // Fold constant c = 2^60 - p, below 2^31 for every channel.
    function automatic logic [C_W-1:0] fold_of(input logic [CH_W-1:0] ch);
        logic [RADIX_BITS:0] d;
        d = ({{RADIX_BITS{1'b0}}, 1'b1} << RADIX_BITS) - {1'b0, prime_of(ch)};
        return d[C_W-1:0];
    endfunction

endpackage

### src/rns_modular_alu.sv
// ----------------------------------------------------------------------------
// rns_modular_alu - residue channel modular add, subtract and multiply
// Top level: the arithmetic pipeline followed by an output register and a
// skid register that decouple the result side from the operation side.
// ----------------------------------------------------------------------------
// Each operation word names an operation (add, multiply or subtract), one of
// four residue channels whose prime has the form 2^60 - c, and two 60-bit
// residues; exactly one result word comes back per operation word, in order.
// The block takes a new word every cycle and returns one result per cycle
// while the skid register is empty. The first of the seven pipeline stages
// captures the word at the accepting edge, the other six follow the multiply
// path (assembly of the 120-bit product, two multiply-and-fold steps by c and
// the final fold with its correction), and the output register follows the
// last stage before the result is offered. Add and subtract finish in the
// first stage and ride along so that results keep their order. Operands
// are assumed canonical and are not checked; an unused operation code gives
// zero. When the result side stalls, the skid register catches the word that
// is already leaving the pipeline, and the whole pipeline then holds until
// the skid register drains, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module rns_modular_alu
    import rnsalu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  logic [1:0]            cmd,
    input  logic [CH_W-1:0]       channel,
    input  logic [RADIX_BITS-1:0] operand_a,
    input  logic [RADIX_BITS-1:0] operand_b,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [RADIX_BITS-1:0] result
);

    op_t                   in_op;
    logic                  pipe_en;
    logic                  pipe_valid;
    logic [RADIX_BITS-1:0] pipe_result;
    logic                  push;
    logic                  pop;

    logic                  res_valid_reg, res_valid_next;
    logic [RADIX_BITS-1:0] result_reg, result_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [RADIX_BITS-1:0] skid_data_reg, skid_data_next;

    assign in_op.cmd     = cmd;
    assign in_op.channel = channel;
    assign in_op.a       = operand_a;
    assign in_op.b       = operand_b;

    // The pipeline moves only while the skid register has room, which keeps
    // the ready path free of the result side's ready.
    assign pipe_en  = !skid_valid_reg;
    assign op_ready = pipe_en;

    rnsalu_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (op_valid && op_ready),
        .in_op      (in_op),
        .out_valid  (pipe_valid),
        .out_result (pipe_result)
    );

    // A word leaves the pipeline whenever it advances with a valid last stage.
    assign push = pipe_en && pipe_valid;
    assign pop  = res_valid_reg && res_ready;

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        result_next     = result_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!res_valid_reg || pop)
        begin
            // The output register is free: the older skid word goes first.
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                result_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_valid_next = push;
                result_next    = pipe_result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

    // The skid register only ever holds a word behind a full output register.
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid_reg && !res_ready))
        else $error("skid register filled without an output stall");

    // A taken result drains the skid register, since the pipeline was held.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && res_ready) |=> !skid_valid_reg)
        else $error("skid register did not drain after a taken result");

endmodule

### src/rnsalu_pipe.sv
// ----------------------------------------------------------------------------
// rnsalu_pipe - seven-stage modular arithmetic pipeline
// Add and subtract finish in the first stage; multiply forms the 120-bit
// product from 30-bit partial products and folds it three times at bit 60.
// All stages advance together on en; valid bits travel with the data.
// ----------------------------------------------------------------------------
module rnsalu_pipe
    import rnsalu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  op_t                   in_op,
    output logic                  out_valid,
    output logic [RADIX_BITS-1:0] out_result
);

    logic [6:0] valid_reg;

    // Per-stage payload registers.
    logic [RADIX_BITS-1:0] s1_p00_reg, s1_p01_reg, s1_p10_reg, s1_p11_reg;
    logic [RADIX_BITS-1:0] s1_alt_reg, s2_alt_reg, s3_alt_reg, s4_alt_reg;
    logic [RADIX_BITS-1:0] s5_alt_reg, s6_alt_reg, s7_res_reg;
    logic [6:1]            is_mul_reg;
    logic [CH_W-1:0]       ch_reg [1:6];
    logic [RADIX_BITS-1:0] s2_xlo_reg, s2_xhi_reg, s3_xlo_reg;
    logic [RADIX_BITS:0]   s3_s_reg, s3_u_reg;
    logic [RADIX_BITS-1:0] s4_ylo_reg, s5_ylo_reg;
    logic [31:0]           s4_yhi_reg;
    logic [62:0]           s5_m_reg, s6_z_reg;

    // Stage 1 logic: decode, add/subtract, partial products.
    logic [RADIX_BITS-1:0] s1_p;
    logic [RADIX_BITS:0]   s1_sum;
    logic [RADIX_BITS+1:0] s1_sum_m_p;
    logic [RADIX_BITS:0]   s1_amb;
    logic [RADIX_BITS-1:0] s1_add_r, s1_sub_r, s1_wrap;
    logic [RADIX_BITS-1:0] s1_alt_next;
    logic                  s1_mul_next;
    logic                  s1_ch_ok;
    logic [HALF_BITS-1:0]  a0, a1, b0, b1;

    assign a0 = in_op.a[HALF_BITS-1:0];
    assign a1 = in_op.a[RADIX_BITS-1:HALF_BITS];
    assign b0 = in_op.b[HALF_BITS-1:0];
    assign b1 = in_op.b[RADIX_BITS-1:HALF_BITS];

    always_comb
    begin
        s1_p       = prime_of(in_op.channel);
        s1_sum     = {1'b0, in_op.a} + {1'b0, in_op.b};
        s1_sum_m_p = {1'b0, s1_sum} - {2'b0, s1_p};
        s1_add_r   = s1_sum_m_p[RADIX_BITS+1] ? s1_sum[RADIX_BITS-1:0]
                                              : s1_sum_m_p[RADIX_BITS-1:0];
        s1_amb     = {1'b0, in_op.a} - {1'b0, in_op.b};
        s1_wrap    = s1_p + s1_amb[RADIX_BITS-1:0];
        s1_sub_r   = s1_amb[RADIX_BITS] ? s1_wrap : s1_amb[RADIX_BITS-1:0];
        s1_ch_ok   = ({1'b0, in_op.channel} < 3'(NUM_CHANNELS));
        s1_alt_next = '0;
        s1_mul_next = 1'b0;
        case (in_op.cmd)
            CMD_ADD: s1_alt_next = s1_add_r;
            CMD_MUL: s1_mul_next = 1'b1;
            CMD_SUB: s1_alt_next = s1_sub_r;
            default: s1_alt_next = '0;
        endcase
        if (!s1_ch_ok)
        begin
            s1_alt_next = '0;
            s1_mul_next = 1'b0;
        end
    end

    // Stage 2 logic: assemble the 120-bit product as xhi:xlo.
    logic [RADIX_BITS:0]   s2_mid, s2_t;
    logic [RADIX_BITS-1:0] s2_xhi_next;

    always_comb
    begin
        s2_mid = {1'b0, s1_p01_reg} + {1'b0, s1_p10_reg};
        s2_t   = {1'b0, s1_p00_reg} + {1'b0, s2_mid[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
        s2_xhi_next = s1_p11_reg + {29'b0, s2_mid[RADIX_BITS:HALF_BITS]}
                    + {59'b0, s2_t[RADIX_BITS]};
    end

    // Stage 3 logic: halves of xhi times c.
    logic [C_W-1:0] s3_c;
    assign s3_c = fold_of(ch_reg[2]);

    // Stage 4 logic: first fold, y = xlo + xhi * c.
    logic [RADIX_BITS+1:0] s4_w;
    logic [RADIX_BITS:0]   s4_t;
    logic [31:0]           s4_phi;
    logic [31:0]           s4_yhi_next;

    always_comb
    begin
        s4_w   = {1'b0, s3_s_reg} + {2'b0, s3_u_reg[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
        s4_phi = {30'b0, s4_w[RADIX_BITS+1:RADIX_BITS]} + {1'b0, s3_u_reg[RADIX_BITS:HALF_BITS]};
        s4_t   = {1'b0, s3_xlo_reg} + {1'b0, s4_w[RADIX_BITS-1:0]};
        s4_yhi_next = s4_phi + {31'b0, s4_t[RADIX_BITS]};
    end

    // Stage 5 logic: second fold product yhi * c.
    logic [C_W-1:0] s5_c;
    assign s5_c = fold_of(ch_reg[4]);

    // Stage 7 logic: third fold and final correction.
    logic [C_W-1:0]        s7_c;
    logic [RADIX_BITS-1:0] s7_p;
    logic [33:0]           s7_zc;
    logic [RADIX_BITS:0]   s7_v;
    logic [RADIX_BITS+1:0] s7_vmp;
    logic [RADIX_BITS-1:0] s7_res_next;

    always_comb
    begin
        s7_c   = fold_of(ch_reg[6]);
        s7_p   = prime_of(ch_reg[6]);
        s7_zc  = {31'b0, s6_z_reg[62:60]} * {3'b0, s7_c};
        s7_v   = {1'b0, s6_z_reg[RADIX_BITS-1:0]} + {27'b0, s7_zc};
        s7_vmp = {1'b0, s7_v} - {2'b0, s7_p};
        if (!is_mul_reg[6])
            s7_res_next = s6_alt_reg;
        else if (s7_vmp[RADIX_BITS+1])
            s7_res_next = s7_v[RADIX_BITS-1:0];
        else
            s7_res_next = s7_vmp[RADIX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p00_reg    <= {30'b0, a0} * {30'b0, b0};
            s1_p01_reg    <= {30'b0, a0} * {30'b0, b1};
            s1_p10_reg    <= {30'b0, a1} * {30'b0, b0};
            s1_p11_reg    <= {30'b0, a1} * {30'b0, b1};
            s1_alt_reg    <= s1_alt_next;
            is_mul_reg    <= {is_mul_reg[5:1], s1_mul_next};
            ch_reg[1]     <= in_op.channel;
            for (int i = 2; i <= 6; i++)
                ch_reg[i] <= ch_reg[i-1];

            s2_xlo_reg    <= s2_t[RADIX_BITS-1:0];
            s2_xhi_reg    <= s2_xhi_next;
            s2_alt_reg    <= s1_alt_reg;

            s3_s_reg      <= {31'b0, s2_xhi_reg[HALF_BITS-1:0]} * {30'b0, s3_c};
            s3_u_reg      <= {31'b0, s2_xhi_reg[RADIX_BITS-1:HALF_BITS]} * {30'b0, s3_c};
            s3_xlo_reg    <= s2_xlo_reg;
            s3_alt_reg    <= s2_alt_reg;

            s4_ylo_reg    <= s4_t[RADIX_BITS-1:0];
            s4_yhi_reg    <= s4_yhi_next;
            s4_alt_reg    <= s3_alt_reg;

            s5_m_reg      <= {31'b0, s4_yhi_reg} * {32'b0, s5_c};
            s5_ylo_reg    <= s4_ylo_reg;
            s5_alt_reg    <= s4_alt_reg;

            s6_z_reg      <= s5_m_reg + {3'b0, s5_ylo_reg};
            s6_alt_reg    <= s5_alt_reg;

            s7_res_reg    <= s7_res_next;
        end
    end

    assign out_valid  = valid_reg[6];
    assign out_result = s7_res_reg;

endmodule

### tb/tb_rns_modular_alu.sv
// ----------------------------------------------------------------------------
// tb_rns_modular_alu - self-checking testbench for the residue modular ALU
// Drives operation words through the valid/ready input channel, predicts each
// result from an independent model of the modular arithmetic and compares it
// with the result words in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_rns_modular_alu;

    import rnsalu_pkg::*;

    typedef bit [RADIX_BITS-1:0] residue_t;

    // The package names only the three live operations; the fourth code
    // must come back as zero.
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Channel primes, all of the form 2^60 - c with c below 2^31.
    localparam residue_t P0 = 60'd1152921504002872321;
    localparam residue_t P1 = 60'd1152921503566671361;
    localparam residue_t P2 = 60'd1152921503264686081;
    localparam residue_t P3 = 60'd1152921503096916481;
    localparam residue_t ALL_ONES = '1;

    localparam int RANDOM_WORDS = 1680;
    // The final stretch of the run is driven with no idling at all.
    localparam int CALM_WORDS   = 200;
    // Covers the latency through the block, with a good margin.
    localparam int DRAIN_CYCLES = 24;
    // Longest quiet spell of a correct run is one send gap, one receive stall
    // and the pipeline latency; the limit is many times that.
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [1:0]      op;
        logic [CH_W-1:0] ch;
        residue_t        a;
        residue_t        b;
        bit              known;
        residue_t        want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  op_valid;
    logic                  op_ready;
    logic [1:0]            cmd;
    logic [CH_W-1:0]       channel;
    logic [RADIX_BITS-1:0] operand_a;
    logic [RADIX_BITS-1:0] operand_b;
    logic                  res_valid;
    logic                  res_ready;
    logic [RADIX_BITS-1:0] result;

    residue_t  pending_residues[$];
    stim_row_t directed_rows[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        words_sent = 0;
    // 0: no idling, 1: light idling, 2: heavy idling.  Shared by both sides.
    int        idle_level = 0;

    rns_modular_alu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .cmd       (cmd),
        .channel   (channel),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic residue_t channel_prime(input logic [CH_W-1:0] ch);
        case (ch)
            2'd0:    return P0;
            2'd1:    return P1;
            2'd2:    return P2;
            default: return P3;
        endcase
    endfunction

    // Product modulo p by folding at bit 60: 2^60 is congruent to c = 2^60 - p,
    // so the high part times c is added back onto the low part.  Three folds
    // and one subtraction mirror the hardware exactly, which matters for
    // operands at or above the prime where the result may stay non-canonical.
    function automatic residue_t folded_product(input residue_t a, input residue_t b,
                                                input residue_t p);
        bit [127:0] acc;
        bit [127:0] k;
        k   = (128'd1 << RADIX_BITS) - 128'(p);
        acc = 128'(a) * 128'(b);
        repeat (3)
            acc = 128'(acc[RADIX_BITS-1:0]) + (acc >> RADIX_BITS) * k;
        if (acc >= 128'(p))
            acc = acc - 128'(p);
        return acc[RADIX_BITS-1:0];
    endfunction

    // Expected residue of one operation word.
    function automatic residue_t residue_of(input logic [1:0] op, input logic [CH_W-1:0] ch,
                                            input residue_t a, input residue_t b);
        bit [63:0] acc;
        residue_t  p;
        p = channel_prime(ch);
        case (op)
            CMD_ADD:
            begin
                acc = 64'(a) + 64'(b);
                if (acc >= 64'(p))
                    acc = acc - 64'(p);
            end
            CMD_SUB:
            begin
                // A negative difference wraps in 64 bits before masking.
                if (a >= b)
                    acc = 64'(a) - 64'(b);
                else
                    acc = 64'(p) - (64'(b) - 64'(a));
            end
            CMD_MUL:
                acc = 64'(folded_product(a, b, p));
            default:
                acc = '0;
        endcase
        return acc[RADIX_BITS-1:0];
    endfunction

    function automatic residue_t random_residue();
        bit [63:0] w;
        w = {$urandom, $urandom};
        return w[RADIX_BITS-1:0];
    endfunction

    // Operand mix: mostly canonical random residues, with boundary values,
    // small values and some words at or above the prime.
    function automatic residue_t pick_operand(input logic [CH_W-1:0] ch);
        residue_t p;
        residue_t c;
        residue_t v;
        p = channel_prime(ch);
        c = ALL_ONES - p + 1'b1;
        case ($urandom_range(0, 19))
            0:       v = '0;
            1:       v = 60'd1;
            2:       v = p - 1'b1;
            3:       v = p - 60'd2;
            4:       v = 60'($urandom_range(0, 1000));
            5:       v = p + 60'($urandom_range(0, 32'(c - 1'b1)));
            6:       v = ALL_ONES;
            7:       v = (p - 1'b1) - 60'($urandom);
            default:
            begin
                v = random_residue();
                if (v >= p)
                    v = v - p;
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_op();
        if ($urandom_range(0, 19) == 0)
            return CMD_NONE;
        case ($urandom_range(0, 2))
            0:       return CMD_ADD;
            1:       return CMD_MUL;
            default: return CMD_SUB;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [CH_W-1:0] ch,
                           input residue_t a, input residue_t b,
                           input bit known, input residue_t want);
        stim_row_t row;
        row = '{op, ch, a, b, known, want};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offers one word and holds it until it is taken.  The expected residue
    // is queued at the edge of acceptance; a random gap may follow.
    task automatic send_word(input stim_row_t row);
        op_valid  <= 1'b1;
        cmd       <= row.op;
        channel   <= row.ch;
        operand_a <= row.a;
        operand_b <= row.b;
        @(posedge clk);
        while (!op_ready)
            @(posedge clk);
        pending_residues.insert(pending_residues.size(),
                                row.known ? row.want
                                          : residue_of(row.op, row.ch, row.a, row.b));
        words_sent++;
        if (idle_level > 0 && $urandom_range(0, 99) < (idle_level == 1 ? 10 : 35))
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // Stimulus: the directed table first, then random words in phases of
    // varying idle pressure, ending with a calm stretch.
    initial
    begin
        stim_row_t row;
        rst_n     = 1'b0;
        op_valid  = 1'b0;
        cmd       = CMD_ADD;
        channel   = '0;
        operand_a = '0;
        operand_b = '0;

        // Boundary sums and differences, with the expected value plain to see.
        add_row(CMD_ADD, 2'd0, '0, '0, 1'b1, '0);
        add_row(CMD_ADD, 2'd0, P0 - 1'b1, 60'd1, 1'b1, '0);
        add_row(CMD_ADD, 2'd3, P3 - 1'b1, P3 - 1'b1, 1'b1, P3 - 60'd2);
        add_row(CMD_SUB, 2'd0, '0, 60'd1, 1'b1, P0 - 1'b1);
        add_row(CMD_SUB, 2'd1, 60'd5, 60'd5, 1'b1, '0);
        add_row(CMD_SUB, 2'd2, P2 - 1'b1, '0, 1'b1, P2 - 1'b1);
        // Products at the extremes: (-1)(-1) = 1, zero, one, (-1)(2) = -2.
        add_row(CMD_MUL, 2'd0, P0 - 1'b1, P0 - 1'b1, 1'b1, 60'd1);
        add_row(CMD_MUL, 2'd1, '0, P1 - 1'b1, 1'b1, '0);
        add_row(CMD_MUL, 2'd2, 60'd1, P2 - 1'b1, 1'b1, P2 - 1'b1);
        add_row(CMD_MUL, 2'd3, P3 - 1'b1, 60'd2, 1'b1, P3 - 60'd2);
        // The unused operation code returns zero whatever the operands.
        add_row(CMD_NONE, 2'd0, P0 - 1'b1, P0 - 1'b1, 1'b1, '0);
        add_row(CMD_NONE, 2'd3, ALL_ONES, ALL_ONES, 1'b1, '0);
        // Operands, some at or above the prime, run through the same datapath.
        add_row(CMD_SUB, 2'd3, P3, P3, 1'b1, '0);
        add_row(CMD_ADD, 2'd1, ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(CMD_SUB, 2'd0, '0, ALL_ONES, 1'b0, '0);
        add_row(CMD_MUL, 2'd2, ALL_ONES, ALL_ONES, 1'b0, '0);
        add_row(CMD_MUL, 2'd0, P0, 60'd3, 1'b0, '0);
        add_row(CMD_MUL, 2'd3, 60'd1 << 59, 60'd1 << 59, 1'b0, '0);
        add_row(CMD_MUL, 2'd1, 60'h3fffffff, 60'h3fffffff << 30, 1'b0, '0);
        add_row(CMD_ADD, 2'd2, P2 - 1'b1, ALL_ONES, 1'b0, '0);
        add_row(CMD_SUB, 2'd1, 60'd1, P1 - 1'b1, 1'b0, '0);

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        idle_level = 1;
        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n >= RANDOM_WORDS - CALM_WORDS)
                idle_level = 0;
            else if (n % 150 == 0)
                idle_level = $urandom_range(0, 2);
            row.op    = pick_op();
            row.ch    = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            row.a     = pick_operand(row.ch);
            row.b     = pick_operand(row.ch);
            row.known = 1'b0;
            row.want  = '0;
            send_word(row);
        end
        op_valid <= 1'b0;

        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb_rns_modular_alu passed");
        else
            $display("tb_rns_modular_alu failed");
        $finish;
    end

    // Result side: ready in runs of random length, which may be broken by
    // stalls of random length when idling is enabled.
    initial
    begin
        res_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 20))
                @(posedge clk);
            if (idle_level > 0 && $urandom_range(0, 2) < idle_level)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 9))
                    @(posedge clk);
            end
        end
    end

    // Each accepted result word is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_result
        residue_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_residues.size() == 0)
            begin
                $display("%0t: result word with none expected, expected none, got %0d",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_residues.pop_front();
                if (result !== want)
                begin
                    $display("%0t: result mismatch, expected %0d, got %0d",
                             $time, want, result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (op_valid && op_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d words sent, %0d pending",
                     $time, quiet_cycles, words_sent, pending_residues.size());
            $display("tb_rns_modular_alu failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

### filelist.f
src/rnsalu_pkg.sv
src/rnsalu_pipe.sv
src/rns_modular_alu.sv
tb/tb_rns_modular_alu.sv
